[design/vt_pkg.sv]
// Shared types and constants for the vertex transform block.
// No dependencies; used by vt_row_lane and vertex_transform_project.
`timescale 1ns / 1ps
`default_nettype none

package vt_pkg;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 8;
    localparam int REG_W     = 64;
    localparam int COEF_W    = 32;
    localparam int FIELD_W   = 32;

    localparam logic [REG_W-1:0] COEF_RESET [NUM_REGS] = '{
        64'h0001_0000_0000_0000, 64'h0,
        64'h0000_0000_0001_0000, 64'h0,
        64'h0,                   64'h0001_0000_0000_0000,
        64'h0,                   64'h0000_0000_0001_0000
    };

    // load enables for the two registered stages of a row lane
    typedef struct packed {
        logic ld_prod;
        logic ld_sum;
    } lane_ctl_t;

    // side data that travels next to the divider lanes
    typedef struct packed {
        logic signed [FIELD_W-1:0] cx;
        logic signed [FIELD_W-1:0] cy;
        logic signed [FIELD_W-1:0] cz;
        logic signed [FIELD_W-1:0] cw;
        logic                      sx;
        logic                      sy;
        logic                      sz;
        logic                      sw;
        logic                      div;
        logic                      ovf;
    } side_t;

endpackage

`default_nettype wire

[design/vt_row_lane.sv]
// One matrix row: four products, exact sum, round to nearest, saturate.
// Depends on vt_pkg (lane_ctl_t, COEF_W, REG_W).
`timescale 1ns / 1ps
`default_nettype none

module vt_row_lane #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire vt_pkg::lane_ctl_t             ctl,
    input  wire logic [vt_pkg::REG_W-1:0]      coef_lo,
    input  wire logic [vt_pkg::REG_W-1:0]      coef_hi,
    input  wire logic signed [COORD_WIDTH-1:0] vx,
    input  wire logic signed [COORD_WIDTH-1:0] vy,
    input  wire logic signed [COORD_WIDTH-1:0] vz,
    input  wire logic signed [COORD_WIDTH-1:0] vw,
    output logic signed [COORD_WIDTH-1:0]      clip,
    output logic                               ovf
);

    localparam int PW = vt_pkg::COEF_W + COORD_WIDTH;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] LO = -HI - SW'(1);
    localparam logic signed [SW-1:0] HALF = SW'(64'sd1 <<< (FRAC_BITS - 1));

    logic signed [vt_pkg::COEF_W-1:0] c [4];
    logic signed [COORD_WIDTH-1:0]    v [4];
    logic signed [PW-1:0]             prod_reg [4];
    logic signed [SW-1:0]             sum_c;
    logic signed [SW-1:0]             rnd_c;
    logic signed [COORD_WIDTH-1:0]    clip_reg;
    logic                             ovf_reg;

    assign c[0] = coef_lo[63:32];
    assign c[1] = coef_lo[31:0];
    assign c[2] = coef_hi[63:32];
    assign c[3] = coef_hi[31:0];
    assign v[0] = vx;
    assign v[1] = vy;
    assign v[2] = vz;
    assign v[3] = vw;

    always_ff @(posedge clk)
    begin
        if (ctl.ld_prod)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_reg[j] <= PW'(c[j]) * PW'(v[j]);
            end
        end
    end

    always_comb
    begin
        sum_c = {{2{prod_reg[0][PW-1]}}, prod_reg[0]}
              + {{2{prod_reg[1][PW-1]}}, prod_reg[1]}
              + {{2{prod_reg[2][PW-1]}}, prod_reg[2]}
              + {{2{prod_reg[3][PW-1]}}, prod_reg[3]};
        // ties go toward plus infinity
        rnd_c = (sum_c + HALF) >>> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_sum)
        begin
            if (rnd_c > HI)
            begin
                clip_reg <= HI[COORD_WIDTH-1:0];
                ovf_reg  <= 1'b1;
            end
            else if (rnd_c < LO)
            begin
                clip_reg <= LO[COORD_WIDTH-1:0];
                ovf_reg  <= 1'b1;
            end
            else
            begin
                clip_reg <= rnd_c[COORD_WIDTH-1:0];
                ovf_reg  <= 1'b0;
            end
        end
    end

    assign clip = clip_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

[design/vt_div_lane.sv]
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module vt_div_lane #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire logic [COORD_WIDTH+FRAC_BITS-1:0]    ld,
    input  wire logic [COORD_WIDTH+FRAC_BITS-1:0]    dvd,
    input  wire logic [COORD_WIDTH-1:0]              dvs,
    output logic [COORD_WIDTH+FRAC_BITS-1:0]         quo
);

    localparam int N = COORD_WIDTH + FRAC_BITS;

    logic [COORD_WIDTH-1:0] rem_reg [N];
    logic [N-1:0]           dq_reg  [N];
    logic [COORD_WIDTH-1:0] d_reg   [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [COORD_WIDTH-1:0] rem_in;
        logic [N-1:0]           dq_in;
        logic [COORD_WIDTH-1:0] d_in;
        logic [COORD_WIDTH:0]   trial;
        logic [COORD_WIDTH:0]   diff;
        logic                   ge;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign dq_in  = dvd;
            assign d_in   = dvs;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign dq_in  = dq_reg[k-1];
            assign d_in   = d_reg[k-1];
        end

        assign trial = {rem_in, dq_in[N-1]};
        assign diff  = trial - {1'b0, d_in};
        assign ge    = (trial >= {1'b0, d_in});

        always_ff @(posedge clk)
        begin
            if (ld[k])
            begin
                rem_reg[k] <= ge ? diff[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
                dq_reg[k]  <= {dq_in[N-2:0], ge};
                d_reg[k]   <= d_in;
            end
        end
    end

    assign quo = dq_reg[N-1];

endmodule

`default_nettype wire

[design/vertex_transform_project.sv]
// Top level: 4x4 vertex transform with perspective divide, Q.FRAC_BITS fixed point.
// Depends on vt_pkg, vt_row_lane (four rows) and vt_div_lane (x, y, z quotients).
//
//  channel | signals                                  | direction
//  in      | in_valid, in_stall, in_x..in_w           | vertex in
//  out     | out_valid, out_stall, out_x..out_w, flags| result out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| register write
//
// One vertex per cycle sustained while out_stall is low. The stages are input, product,
// clip, divide setup, the divider lanes (one quotient bit per stage) and output.
// Each stage advances unless it and every stage after it hold items and out_stall is
// high, so bubbles collapse and an item is taken while a result waits.
// Reset clears the stage valid bits and loads the identity matrix.
`timescale 1ns / 1ps
`default_nettype none

module vertex_transform_project #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [31:0]             in_x,
    input  wire logic signed [31:0]             in_y,
    input  wire logic signed [31:0]             in_z,
    input  wire logic signed [31:0]             in_w,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [31:0]                  out_x,
    output logic signed [31:0]                  out_y,
    output logic signed [31:0]                  out_z,
    output logic signed [31:0]                  out_w,
    output logic                                divided,
    output logic                                overflow,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [vt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vt_pkg::REG_W-1:0]       cfg_data
);

    localparam int CW     = COORD_WIDTH;
    localparam int N      = COORD_WIDTH + FRAC_BITS;
    localparam int S_IN   = 0;
    localparam int S_PROD = 1;
    localparam int S_CLIP = 2;
    localparam int S_PREP = 3;
    localparam int S_DIV0 = 4;
    localparam int S_OUT  = N + 4;
    localparam int NS     = N + 5;
    localparam logic [N-1:0] QMAX_POS = N'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic [N-1:0] QMAX_NEG = N'(64'd1 << (CW - 1));

    // ---------------- configuration ----------------
    logic [vt_pkg::REG_W-1:0] coef_reg [vt_pkg::NUM_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vt_pkg::NUM_REGS; i++)
            begin
                coef_reg[i] <= vt_pkg::COEF_RESET[i];
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int i = 0; i < vt_pkg::NUM_REGS; i++)
            begin
                if (cfg_index == vt_pkg::CFG_IDX_W'(i))
                begin
                    coef_reg[i] <= cfg_data;
                end
            end
        end
    end

    // ---------------- stage flow control ----------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] rdy;

    always_comb
    begin
        logic full;
        full = out_stall;
        for (int i = NS - 1; i >= 0; i--)
        begin
            full   = full & vld_reg[i];
            rdy[i] = ~full;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (!rdy[i])
            begin
                vld_next[i] = vld_reg[i];
            end
            else if (i == 0)
            begin
                vld_next[i] = in_valid;
            end
            else
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = ~rdy[S_IN];
    assign out_valid = vld_reg[S_OUT];

    // ---------------- input stage ----------------
    logic signed [CW-1:0] v_reg [4];

    always_ff @(posedge clk)
    begin
        if (rdy[S_IN])
        begin
            v_reg[0] <= in_x[CW-1:0];
            v_reg[1] <= in_y[CW-1:0];
            v_reg[2] <= in_z[CW-1:0];
            v_reg[3] <= in_w[CW-1:0];
        end
    end

    // ---------------- row lanes ----------------
    vt_pkg::lane_ctl_t    lane_ctl;
    logic signed [CW-1:0] clip [4];
    logic [3:0]           clip_ovf;

    assign lane_ctl.ld_prod = rdy[S_PROD];
    assign lane_ctl.ld_sum  = rdy[S_CLIP];

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        vt_row_lane #(
            .FRAC_BITS   (FRAC_BITS),
            .COORD_WIDTH (COORD_WIDTH)
        ) u_row (
            .clk     (clk),
            .ctl     (lane_ctl),
            .coef_lo (coef_reg[2*r]),
            .coef_hi (coef_reg[2*r+1]),
            .vx      (v_reg[0]),
            .vy      (v_reg[1]),
            .vz      (v_reg[2]),
            .vw      (v_reg[3]),
            .clip    (clip[r]),
            .ovf     (clip_ovf[r])
        );
    end

    // ---------------- divide setup ----------------
    logic [N-1:0]     dvd_reg [3];
    logic [CW-1:0]    dvs_reg;
    vt_pkg::side_t    side_prep_reg;
    logic [CW-1:0]    mag [4];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            mag[r] = clip[r][CW-1] ? (~clip[r] + CW'(1)) : clip[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[S_PREP])
        begin
            for (int r = 0; r < 3; r++)
            begin
                dvd_reg[r] <= {mag[r], {FRAC_BITS{1'b0}}};
            end
            dvs_reg           <= mag[3];
            side_prep_reg.cx  <= 32'(clip[0]);
            side_prep_reg.cy  <= 32'(clip[1]);
            side_prep_reg.cz  <= 32'(clip[2]);
            side_prep_reg.cw  <= 32'(clip[3]);
            side_prep_reg.sx  <= clip[0][CW-1];
            side_prep_reg.sy  <= clip[1][CW-1];
            side_prep_reg.sz  <= clip[2][CW-1];
            side_prep_reg.sw  <= clip[3][CW-1];
            side_prep_reg.div <= (clip[3] != '0);
            side_prep_reg.ovf <= |clip_ovf;
        end
    end

    // ---------------- divider lanes ----------------
    logic [N-1:0]  quo [3];
    vt_pkg::side_t side_reg [N];

    for (genvar r = 0; r < 3; r++)
    begin : g_div
        vt_div_lane #(
            .FRAC_BITS   (FRAC_BITS),
            .COORD_WIDTH (COORD_WIDTH)
        ) u_div (
            .clk (clk),
            .ld  (rdy[S_DIV0 +: N]),
            .dvd (dvd_reg[r]),
            .dvs (dvs_reg),
            .quo (quo[r])
        );
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            if (rdy[S_DIV0 + k])
            begin
                side_reg[k] <= (k == 0) ? side_prep_reg : side_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // ---------------- merge: sign, saturate, select ----------------
    vt_pkg::side_t        sd;
    logic                 neg [3];
    logic signed [31:0]   num [3];
    logic signed [31:0]   res [3];
    logic [2:0]           q_ovf;
    logic signed [CW-1:0] qs;
    logic signed [31:0]   out_reg [4];
    logic                 divided_reg;
    logic                 overflow_reg;

    assign sd = side_reg[N-1];

    always_comb
    begin
        neg[0] = sd.sx ^ sd.sw;
        neg[1] = sd.sy ^ sd.sw;
        neg[2] = sd.sz ^ sd.sw;
        num[0] = sd.cx;
        num[1] = sd.cy;
        num[2] = sd.cz;
        qs     = '0;
        for (int r = 0; r < 3; r++)
        begin
            q_ovf[r] = 1'b0;
            if (neg[r])
            begin
                if (quo[r] > QMAX_NEG)
                begin
                    qs       = QMAX_NEG[CW-1:0];
                    q_ovf[r] = 1'b1;
                end
                else
                begin
                    qs = CW'(~quo[r] + N'(1));
                end
            end
            else
            begin
                if (quo[r] > QMAX_POS)
                begin
                    qs       = QMAX_POS[CW-1:0];
                    q_ovf[r] = 1'b1;
                end
                else
                begin
                    qs = quo[r][CW-1:0];
                end
            end
            res[r] = sd.div ? 32'(qs) : num[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[S_OUT])
        begin
            out_reg[0]   <= res[0];
            out_reg[1]   <= res[1];
            out_reg[2]   <= res[2];
            out_reg[3]   <= sd.cw;
            divided_reg  <= sd.div;
            overflow_reg <= sd.ovf | (sd.div & (|q_ovf));
        end
    end

    assign out_x    = out_reg[0];
    assign out_y    = out_reg[1];
    assign out_z    = out_reg[2];
    assign out_w    = out_reg[3];
    assign divided  = divided_reg;
    assign overflow = overflow_reg;

endmodule

`default_nettype wire
